@@ src/sra_pkg.sv @@
package sra_pkg;

  // Command codes carried on in_cmd.
  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_SUB   = 3'd2,
    CMD_MUL   = 3'd3,
    CMD_QUO   = 3'd4,
    CMD_REM   = 3'd5,
    CMD_READ  = 3'd6
  } cmd_t;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  // Width of a register index on the command port.
  localparam int IDX_BITS = 3;

  // Sequencer to ALU control.
  typedef struct packed {
    logic load;
    cmd_t op;
  } alu_ctl_t;

  // ALU to sequencer status.
  typedef struct packed {
    logic       done;
    logic [1:0] status;
  } alu_stat_t;

endpackage

@@ src/sra_ram.sv @@
module sra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/sra_alu.sv @@
module sra_alu
  import sra_pkg::*;
#(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  alu_ctl_t     ctl,
  input  logic [W-1:0] opa_in,
  input  logic [W-1:0] opb_in,
  output alu_stat_t    stat,
  output logic [W-1:0] val
);

  localparam int CW = $clog2(W + 1);

  cmd_t          op_r, op_nxt;
  logic [W-1:0]  opa_r, opa_nxt;
  logic [W-1:0]  opb_r, opb_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic          cy_r, cy_nxt;
  logic          ovf_r, ovf_nxt;
  logic          bz_r, bz_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;

  logic          bb;
  logic          sbit;
  logic [W+1:0]  mul_sum;
  logic [W:0]    div_rem;
  logic          div_ge;

  // Add and subtract run one bit per step, least significant bit first.
  // Multiply and divide consume one operand bit per step, most significant first.
  always_comb begin
    bb      = opb_r[0] ^ (op_r == CMD_SUB);
    sbit    = opa_r[0] ^ bb ^ cy_r;
    mul_sum = {1'b0, res_r, 1'b0} + (opb_r[W-1] ? {2'b00, opa_r} : '0);
    div_rem = {acc_r, opa_r[W-1]};
    div_ge  = div_rem >= {1'b0, opb_r};
  end

  always_comb begin
    op_nxt   = op_r;
    opa_nxt  = opa_r;
    opb_nxt  = opb_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    cy_nxt   = cy_r;
    ovf_nxt  = ovf_r;
    bz_nxt   = bz_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctl.load) begin
      op_nxt  = ctl.op;
      opa_nxt = opa_in;
      opb_nxt = opb_in;
      acc_nxt = '0;
      res_nxt = '0;
      cy_nxt  = (ctl.op == CMD_SUB);
      ovf_nxt = 1'b0;
      bz_nxt  = (opb_in == '0);
      cnt_nxt = CW'(W);
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
      case (op_r)
        CMD_ADD, CMD_SUB: begin
          cy_nxt  = (opa_r[0] & bb) | (opa_r[0] & cy_r) | (bb & cy_r);
          res_nxt = {sbit, res_r[W-1:1]};
          opa_nxt = {1'b0, opa_r[W-1:1]};
          opb_nxt = {1'b0, opb_r[W-1:1]};
        end
        CMD_MUL: begin
          res_nxt = mul_sum[W-1:0];
          ovf_nxt = ovf_r | (mul_sum[W+1:W] != 2'b00);
          opb_nxt = {opb_r[W-2:0], 1'b0};
        end
        CMD_QUO, CMD_REM: begin
          acc_nxt = div_ge ? W'(div_rem - {1'b0, opb_r}) : div_rem[W-1:0];
          res_nxt = {res_r[W-2:0], div_ge};
          opa_nxt = {opa_r[W-2:0], 1'b0};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    cy_r  <= cy_nxt;
    ovf_r <= ovf_nxt;
    bz_r  <= bz_nxt;
  end

  // Final saturation, clamping, divide-by-zero handling and remainder selection.
  always_comb begin
    stat.done   = done_r;
    stat.status = ST_OK;
    val         = res_r;
    case (op_r)
      CMD_ADD: begin
        if (cy_r) begin
          val         = '1;
          stat.status = ST_SAT;
        end
      end
      CMD_SUB: begin
        if (!cy_r) begin
          val         = '0;
          stat.status = ST_SAT;
        end
      end
      CMD_MUL: begin
        if (ovf_r) begin
          val         = '1;
          stat.status = ST_SAT;
        end
      end
      CMD_QUO, CMD_REM: begin
        if (bz_r) begin
          val         = '0;
          stat.status = ST_DIVZ;
        end else if (op_r == CMD_REM) begin
          val = acc_r;
        end
      end
      default: begin
        val = '0;
      end
    endcase
  end

endmodule

@@ src/saturating_register_alu.sv @@
// Register file of unsigned words with a bit-serial saturating ALU.
// A command item is taken on a rising edge where start is high and busy is
// low. It carries the command, two source indexes, a destination index and
// a write value. Every item yields exactly one result item: out_valid is
// high for one cycle with out_result_value and out_status. The receiver
// cannot stall, so the result must be taken in that cycle.
// Write, read and the unused command finish after the two registered reads
// of the register file RAM. Add, subtract, multiply, quotient and remainder
// then run in the ALU, which handles one operand bit per cycle. busy stays
// high until the result is presented, so one item is in the block at a
// time and the next item can be taken while the result is on the output.
// Reset clears all registers of the file to zero through per-entry valid
// bits, with no clearing pass; the block is ready the cycle after reset.
// Indexes at or above REG_COUNT read as zero and writes to them are dropped.
module saturating_register_alu
  import sra_pkg::*;
#(
  parameter int REG_BITS  = 16,
  parameter int REG_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_cmd,
  input  logic [IDX_BITS-1:0] in_src_a,
  input  logic [IDX_BITS-1:0] in_src_b,
  input  logic [IDX_BITS-1:0] in_dest,
  input  logic [15:0]         in_write_value,
  output logic                out_valid,
  output logic [15:0]         out_result_value,
  output logic [1:0]          out_status
);

  // Only indexes reachable by a 3-bit field get storage.
  localparam int RF_DEPTH = (REG_COUNT < (1 << IDX_BITS)) ? REG_COUNT : (1 << IDX_BITS);
  localparam int AW       = (RF_DEPTH > 1) ? $clog2(RF_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDB,
    S_LDB,
    S_CALC
  } state_t;

  state_t               state_r;
  cmd_t                 cmd_r;
  logic [IDX_BITS-1:0]  src_b_r;
  logic [IDX_BITS-1:0]  dest_r;
  logic [REG_BITS-1:0]  wv_r;
  logic [REG_BITS-1:0]  a_r;
  logic                 rd_ok_r;
  logic [RF_DEPTH-1:0]  valid_r;
  logic                 out_valid_r;
  logic [15:0]          out_result_value_r;
  logic [1:0]           out_status_r;

  logic                 accept;
  logic [IDX_BITS-1:0]  rd_idx;
  logic                 rd_ok_nxt;
  logic [REG_BITS-1:0]  rdata;
  logic [REG_BITS-1:0]  rd_val;
  logic [REG_BITS+15:0] wv_ext;
  logic [REG_BITS+15:0] ov_ext;

  logic                 fin;
  logic                 fin_store;
  logic [REG_BITS-1:0]  fin_val;
  logic [1:0]           fin_st;
  logic                 ram_we;

  alu_ctl_t             alu_ctl;
  alu_stat_t            alu_stat;
  logic [REG_BITS-1:0]  alu_val;

  function automatic logic idx_ok(input logic [IDX_BITS-1:0] idx);
    return int'(idx) < REG_COUNT;
  endfunction

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Source A is addressed on the accept edge, source B in the next cycle (S_RDB).
  assign rd_idx    = (state_r == S_IDLE) ? in_src_a : src_b_r;
  assign rd_ok_nxt = idx_ok(rd_idx) && valid_r[rd_idx[AW-1:0]];
  assign rd_val    = rd_ok_r ? rdata : '0;

  // Write values are kept to REG_BITS bits; results are kept to 16 bits.
  assign wv_ext = {{REG_BITS{1'b0}}, in_write_value};
  assign ov_ext = {16'b0, fin_val};

  sra_ram #(
    .WIDTH (REG_BITS),
    .DEPTH (RF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dest_r[AW-1:0]),
    .wdata (fin_val),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  sra_alu #(
    .W (REG_BITS)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .opa_in (a_r),
    .opb_in (rd_val),
    .stat   (alu_stat),
    .val    (alu_val)
  );

  // Finish decode: non-arithmetic commands finish once both reads are in,
  // arithmetic commands finish when the ALU reports done.
  always_comb begin
    fin          = 1'b0;
    fin_store    = 1'b0;
    fin_val      = '0;
    fin_st       = ST_OK;
    alu_ctl.load = 1'b0;
    alu_ctl.op   = cmd_r;
    if (state_r == S_LDB) begin
      unique case (cmd_r)
        CMD_WRITE: begin
          fin       = 1'b1;
          fin_store = 1'b1;
          fin_val   = wv_r;
        end
        CMD_READ: begin
          fin     = 1'b1;
          fin_val = a_r;
        end
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_QUO, CMD_REM: begin
          alu_ctl.load = 1'b1;
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end else if (state_r == S_CALC && alu_stat.done) begin
      fin       = 1'b1;
      fin_store = 1'b1;
      fin_val   = alu_val;
      fin_st    = alu_stat.status;
    end
  end

  assign ram_we = fin && fin_store && idx_ok(dest_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin;
      rd_ok_r     <= rd_ok_nxt;
      if (ram_we) begin
        valid_r[dest_r[AW-1:0]] <= 1'b1;
      end
      if (fin) begin
        out_result_value_r <= ov_ext[15:0];
        out_status_r       <= fin_st;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= cmd_t'(in_cmd);
            src_b_r <= in_src_b;
            dest_r  <= in_dest;
            wv_r    <= wv_ext[REG_BITS-1:0];
            state_r <= S_RDB;
          end
        end
        S_RDB: begin
          a_r     <= rd_val;
          state_r <= S_LDB;
        end
        S_LDB: begin
          state_r <= fin ? S_IDLE : S_CALC;
        end
        S_CALC: begin
          if (fin) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_value_r;
  assign out_status       = out_status_r;

endmodule

@@ verif/saturating_register_alu_tb.sv @@
`timescale 1ns / 100ps

module saturating_register_alu_tb;
  import sra_pkg::*;

  // Code 3'd7 is not a command; the block must answer it with a zero result
  // and leave the register file alone.
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int NUM_RANDOM = 850;
  localparam int DRAIN_CYCLES = 30;

  // Tracks the register file as the block should see it, and holds the
  // results that accepted command items are still owed, oldest first.
  class alu_outcome_tracker;
    logic [15:0] regs [8];
    logic [15:0] owed_value [$];
    logic [1:0]  owed_status [$];
    int errors;
    int commands;
    int saturated;
    int div_zero;
    int unused_codes;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
      commands = 0;
      saturated = 0;
      div_zero = 0;
      unused_codes = 0;
    endfunction

    function int pending();
      return owed_value.size();
    endfunction

    // Works out the result of one accepted command item and updates the
    // register file copy the same way the block should.
    function void predict_command(logic [2:0] cmd, logic [2:0] a_idx, logic [2:0] b_idx,
                                  logic [2:0] d_idx, logic [15:0] wv);
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] v;
      logic [1:0]  st;
      logic [16:0] sum;
      logic [31:0] prod;
      bit          store;
      a = regs[a_idx];
      b = regs[b_idx];
      v = '0;
      st = ST_OK;
      store = 1'b1;
      commands++;
      case (cmd)
        CMD_WRITE: v = wv;
        CMD_ADD: begin
          sum = {1'b0, a} + {1'b0, b};
          if (sum[16]) begin
            v = 16'hFFFF;
            st = ST_SAT;
          end else begin
            v = sum[15:0];
          end
        end
        CMD_SUB: begin
          if (a < b) st = ST_SAT;
          else v = a - b;
        end
        CMD_MUL: begin
          prod = {16'd0, a} * {16'd0, b};
          if (prod[31:16] != '0) begin
            v = 16'hFFFF;
            st = ST_SAT;
          end else begin
            v = prod[15:0];
          end
        end
        CMD_QUO, CMD_REM: begin
          if (b == '0) st = ST_DIVZ;
          else if (cmd == CMD_QUO) v = a / b;
          else v = a % b;
        end
        CMD_READ: begin
          v = a;
          store = 1'b0;
        end
        default: begin
          store = 1'b0;
          unused_codes++;
        end
      endcase
      if (store) regs[d_idx] = v;
      if (st == ST_SAT) saturated++;
      if (st == ST_DIVZ) div_zero++;
      owed_value.push_back(v);
      owed_status.push_back(st);
    endfunction

    // Compares one result item against the oldest owed result.
    function void compare_result(logic [15:0] value, logic [1:0] status);
      logic [15:0] want_v;
      logic [1:0]  want_s;
      if (owed_value.size() == 0) begin
        $display("%0t unexpected result: expected none, actual value %h status %0d",
                 $time, value, status);
        errors++;
        return;
      end
      want_v = owed_value.pop_front();
      want_s = owed_status.pop_front();
      if (value !== want_v) begin
        $display("%0t value mismatch: expected %h, actual %h", $time, want_v, value);
        errors++;
      end
      if (status !== want_s) begin
        $display("%0t status mismatch: expected %0d, actual %0d", $time, want_s, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_cmd;
  logic [2:0]  in_src_a;
  logic [2:0]  in_src_b;
  logic [2:0]  in_dest;
  logic [15:0] in_write_value;
  logic        out_valid;
  logic [15:0] out_result_value;
  logic [1:0]  out_status;

  alu_outcome_tracker tracker;
  bit idle_enabled;

  saturating_register_alu uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_src_a         (in_src_a),
    .in_src_b         (in_src_b),
    .in_dest          (in_dest),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Everything is sampled on the rising edge, where the values seen are the
  // ones settled before the edge. An item is taken where start is high and
  // busy is low; a result is taken wherever out_valid is high, since the
  // receiver has no way to hold it off.
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      tracker.predict_command(in_cmd, in_src_a, in_src_b, in_dest, in_write_value);
    if (rst_n && out_valid)
      tracker.compare_result(out_result_value, out_status);
  end

  // Presents one command item. Fields change on the falling edge only. The
  // first falling edge after the previous accept either lowers start for a
  // gap or loads the next item straight away, so start is never dropped and
  // raised in the same step.
  task automatic send(logic [2:0] cmd, logic [2:0] a_idx, logic [2:0] b_idx,
                      logic [2:0] d_idx, logic [15:0] wv);
    int gap;
    gap = idle_enabled ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd <= cmd;
    in_src_a <= a_idx;
    in_src_b <= b_idx;
    in_dest <= d_idx;
    in_write_value <= wv;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Stops sending and waits until every owed result has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // One random item. Writes seed the file with values near the edges so
  // that the arithmetic keeps hitting saturation, clamping and zero
  // divisors; the rest are arithmetic, reads and the odd unused code.
  task automatic send_random();
    int pick;
    logic [15:0] wv;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 5))
      0: wv = 16'h0000;
      1: wv = 16'hFFFF;
      2: wv = 16'($urandom_range(0, 15));
      3: wv = 16'($urandom_range(0, 255));
      default: wv = 16'($urandom);
    endcase
    if (pick < 30) op = CMD_WRITE;
    else if (pick < 36) op = CMD_READ;
    else if (pick < 39) op = CMD_UNUSED;
    else op = 3'($urandom_range(int'(CMD_ADD), int'(CMD_REM)));
    send(op, 3'($urandom), 3'($urandom), 3'($urandom), wv);
  endtask

  initial begin
    tracker = new();
    idle_enabled = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_WRITE;
    in_src_a = '0;
    in_src_b = '0;
    in_dest = '0;
    in_write_value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: reset contents, field extremes, every command and the
    // corner cases of each operation.
    send(CMD_READ, 3'd0, 3'd7, 3'd0, 16'h0000);       // reset value is zero
    send(CMD_WRITE, 3'd0, 3'd0, 3'd1, 16'hFFFF);
    send(CMD_WRITE, 3'd7, 3'd7, 3'd2, 16'h0001);
    send(CMD_WRITE, 3'd0, 3'd0, 3'd3, 16'h0000);
    send(CMD_ADD, 3'd1, 3'd2, 3'd4, 16'h0000);        // add overflows
    send(CMD_WRITE, 3'd0, 3'd0, 3'd5, 16'hFFFE);
    send(CMD_ADD, 3'd5, 3'd2, 3'd6, 16'h0000);        // exactly all ones, no overflow
    send(CMD_SUB, 3'd2, 3'd1, 3'd7, 16'h0000);        // clamped at zero
    send(CMD_SUB, 3'd1, 3'd1, 3'd4, 16'h0000);        // difference exactly zero
    send(CMD_MUL, 3'd1, 3'd1, 3'd4, 16'h0000);        // product overflows
    send(CMD_WRITE, 3'd0, 3'd0, 3'd5, 16'h00FF);
    send(CMD_WRITE, 3'd0, 3'd0, 3'd6, 16'h0101);
    send(CMD_MUL, 3'd5, 3'd6, 3'd7, 16'h0000);        // product exactly all ones
    send(CMD_MUL, 3'd1, 3'd3, 3'd4, 16'h0000);        // multiply by zero
    send(CMD_QUO, 3'd1, 3'd3, 3'd4, 16'h0000);        // divide by zero
    send(CMD_REM, 3'd1, 3'd3, 3'd4, 16'h0000);        // remainder by zero
    send(CMD_WRITE, 3'd0, 3'd0, 3'd5, 16'h1234);
    send(CMD_WRITE, 3'd0, 3'd0, 3'd6, 16'h0007);
    send(CMD_QUO, 3'd5, 3'd6, 3'd0, 16'h0000);
    send(CMD_REM, 3'd5, 3'd6, 3'd0, 16'h0000);
    send(CMD_QUO, 3'd3, 3'd1, 3'd0, 16'h0000);        // small dividend, large divisor
    send(CMD_REM, 3'd2, 3'd1, 3'd1, 16'h0000);        // source and dest overlap
    send(CMD_UNUSED, 3'd7, 3'd7, 3'd1, 16'hFFFF);     // must not touch the file
    send(CMD_READ, 3'd1, 3'd0, 3'd0, 16'hAAAA);
    send(CMD_WRITE, 3'd0, 3'd0, 3'd0, 16'h5555);

    // Random part. Idling is switched off for some stretches so that items
    // also arrive back to back, and now and then the sender holds off until
    // the block has returned everything it owes.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 100 == 0) idle_enabled = ($urandom_range(0, 3) != 0);
      if (i % 170 == 85) drain();
      send_random();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands with random gaps: %0d saturated or clamped,",
             tracker.commands, tracker.saturated);
    $display("%0d divide by zero, %0d unused command codes.",
             tracker.div_zero, tracker.unused_codes);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // The slowest correct run is well under 60 us; anything past this means
  // the block stopped answering.
  initial begin
    #500000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
src/sra_pkg.sv
src/sra_ram.sv
src/sra_alu.sv
src/saturating_register_alu.sv
verif/saturating_register_alu_tb.sv
